[hw/rtl/kst_pkg.sv]
package kst_pkg;

    localparam int SLOTS  = 64;
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int KEY_W  = 32;
    localparam int LIFE_W = 16;
    localparam int STAT_W = 2;
    localparam int SLOT_W = 6;

    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic [STAT_W-1:0] ST_REFRESHED = 2'd0;
    localparam logic [STAT_W-1:0] ST_INSERTED  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] ST_TICK      = 2'd3;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [IDX_W:0]    cnt_t;
    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [LIFE_W-1:0] life_t;

endpackage

[hw/rtl/kst_if.sv]
interface kst_req_if;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [kst_pkg::KEY_W-1:0]    key;
    logic [kst_pkg::LIFE_W-1:0]   lifetime_ms;
    logic [kst_pkg::LIFE_W-1:0]   elapsed_ms;

    modport source (output valid, output func, output key, output lifetime_ms,
                    output elapsed_ms, input ready);
    modport sink   (input valid, input func, input key, input lifetime_ms,
                    input elapsed_ms, output ready);
endinterface

interface kst_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [kst_pkg::STAT_W-1:0]   status;
    logic [kst_pkg::SLOT_W-1:0]   slot;

    modport source (output valid, output status, output slot, input ready);
    modport sink   (input valid, input status, input slot, output ready);
endinterface

[hw/rtl/keyed_slot_table_with_aging.sv]
// An add stops its slot walk early on a hit, while a tick walks every slot; either also
// waits while an older response stalls.
// Throughput: one request at a time; the next request is taken once the response
// is loaded into the output register. The slot walk over the key and lifetime
// memories (one read port each, one slot per cycle) sets this figure.
// Reset: rst_n clears all valid bits at once; no clearing pass is needed.
module keyed_slot_table_with_aging (
    input  logic            clk,
    input  logic            rst_n,
    kst_req_if.sink         req,
    kst_rsp_if.source       rsp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ADD  = 2'd1;
    localparam logic [1:0] S_TICK = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]                  state_reg, state_next;
    logic                        func_reg, func_next;
    kst_pkg::key_t               key_reg, key_next;
    kst_pkg::life_t              life_reg, life_next;
    kst_pkg::life_t              elapsed_reg, elapsed_next;
    logic [kst_pkg::SLOTS-1:0]   valid_reg, valid_next;
    kst_pkg::cnt_t               rd_cnt_reg, rd_cnt_next;
    logic                        pipe_vld_reg, pipe_vld_next;
    kst_pkg::idx_t               pipe_idx_reg, pipe_idx_next;
    logic                        hit_reg, hit_next;
    kst_pkg::idx_t               hit_idx_reg, hit_idx_next;
    logic                        empty_found_reg, empty_found_next;
    kst_pkg::idx_t               empty_idx_reg, empty_idx_next;
    logic                        out_valid_reg, out_valid_next;
    logic [kst_pkg::STAT_W-1:0]  out_status_reg, out_status_next;
    logic [kst_pkg::SLOT_W-1:0]  out_slot_reg, out_slot_next;

    // memories
    kst_pkg::key_t               key_mem [kst_pkg::SLOTS];
    kst_pkg::life_t              life_mem [kst_pkg::SLOTS];
    kst_pkg::key_t               key_rd_reg;
    kst_pkg::life_t              life_rd_reg;

    logic                        rd_en;
    kst_pkg::idx_t               rd_addr;
    logic                        key_we;
    kst_pkg::idx_t               key_waddr;
    logic                        life_we;
    kst_pkg::idx_t               life_waddr;
    kst_pkg::life_t              life_wdata;

    logic                        req_fire;
    logic                        done_go;
    logic                        issue_more;
    logic                        cur_valid;

    assign req_fire   = req.valid && req.ready;
    assign done_go    = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);
    assign issue_more = rd_cnt_reg < (kst_pkg::IDX_W + 1)'(kst_pkg::SLOTS);
    assign cur_valid  = valid_reg[pipe_idx_reg];

    assign req.ready  = (state_reg == S_IDLE);
    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.slot   = out_slot_reg;

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_waddr] <= key_reg;
        end
        if (rd_en)
        begin
            key_rd_reg <= key_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (life_we)
        begin
            life_mem[life_waddr] <= life_wdata;
        end
        if (rd_en)
        begin
            life_rd_reg <= life_mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        func_next        = func_reg;
        key_next         = key_reg;
        life_next        = life_reg;
        elapsed_next     = elapsed_reg;
        valid_next       = valid_reg;
        rd_cnt_next      = rd_cnt_reg;
        pipe_vld_next    = 1'b0;
        pipe_idx_next    = pipe_idx_reg;
        hit_next         = hit_reg;
        hit_idx_next     = hit_idx_reg;
        empty_found_next = empty_found_reg;
        empty_idx_next   = empty_idx_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_status_next  = out_status_reg;
        out_slot_next    = out_slot_reg;
        rd_en            = 1'b0;
        rd_addr          = rd_cnt_reg[kst_pkg::IDX_W-1:0];
        key_we           = 1'b0;
        key_waddr        = empty_idx_reg;
        life_we          = 1'b0;
        life_waddr       = pipe_idx_reg;
        life_wdata       = life_rd_reg - elapsed_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    func_next        = req.func;
                    key_next         = req.key;
                    life_next        = req.lifetime_ms;
                    elapsed_next     = req.elapsed_ms;
                    rd_cnt_next      = '0;
                    hit_next         = 1'b0;
                    empty_found_next = 1'b0;
                    state_next       = (req.func == kst_pkg::FUNC_TICK) ? S_TICK : S_ADD;
                end
            end

            S_ADD:
            begin
                // stop reading once a hit is seen; keys are unique
                if (issue_more && !hit_reg)
                begin
                    rd_en         = 1'b1;
                    rd_cnt_next   = rd_cnt_reg + 1'b1;
                    pipe_vld_next = 1'b1;
                    pipe_idx_next = rd_addr;
                end
                if (pipe_vld_reg)
                begin
                    if (cur_valid && key_rd_reg == key_reg && !hit_reg)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = pipe_idx_reg;
                    end
                    if (!cur_valid && !empty_found_reg)
                    begin
                        empty_found_next = 1'b1;
                        empty_idx_next   = pipe_idx_reg;
                    end
                end
                if ((!issue_more || hit_reg) && !pipe_vld_reg)
                begin
                    state_next = S_DONE;
                end
            end

            S_TICK:
            begin
                if (issue_more)
                begin
                    rd_en         = 1'b1;
                    rd_cnt_next   = rd_cnt_reg + 1'b1;
                    pipe_vld_next = 1'b1;
                    pipe_idx_next = rd_addr;
                end
                if (pipe_vld_reg && cur_valid)
                begin
                    if (elapsed_reg >= life_rd_reg)
                    begin
                        valid_next[pipe_idx_reg] = 1'b0;
                    end
                    else
                    begin
                        life_we = 1'b1;
                    end
                end
                if (!issue_more && !pipe_vld_reg)
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (done_go)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    life_wdata     = life_reg;
                    if (func_reg == kst_pkg::FUNC_TICK)
                    begin
                        out_status_next = kst_pkg::ST_TICK;
                        out_slot_next   = '0;
                    end
                    else if (hit_reg)
                    begin
                        life_we         = 1'b1;
                        life_waddr      = hit_idx_reg;
                        out_status_next = kst_pkg::ST_REFRESHED;
                        out_slot_next   = kst_pkg::SLOT_W'(hit_idx_reg);
                    end
                    else if (empty_found_reg)
                    begin
                        key_we                    = 1'b1;
                        life_we                   = 1'b1;
                        life_waddr                = empty_idx_reg;
                        valid_next[empty_idx_reg] = 1'b1;
                        out_status_next           = kst_pkg::ST_INSERTED;
                        out_slot_next             = kst_pkg::SLOT_W'(empty_idx_reg);
                    end
                    else
                    begin
                        out_status_next = kst_pkg::ST_FULL;
                        out_slot_next   = '0;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            pipe_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            pipe_vld_reg  <= pipe_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg        <= func_next;
        key_reg         <= key_next;
        life_reg        <= life_next;
        elapsed_reg     <= elapsed_next;
        rd_cnt_reg      <= rd_cnt_next;
        pipe_idx_reg    <= pipe_idx_next;
        hit_reg         <= hit_next;
        hit_idx_reg     <= hit_idx_next;
        empty_found_reg <= empty_found_next;
        empty_idx_reg   <= empty_idx_next;
        out_status_reg  <= out_status_next;
        out_slot_reg    <= out_slot_next;
    end

`ifndef SYNTHESIS
    // a tick never marks a slot occupied
    a_tick_no_set: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TICK) |=> ((valid_reg & ~$past(valid_reg)) == '0))
        else $error("tick set a valid bit");

    // full is reported only when every slot is occupied
    a_full_all_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (done_go && func_reg == kst_pkg::FUNC_ADD && !hit_reg && !empty_found_reg)
        |-> (&valid_reg))
        else $error("full reported with an empty slot");

    // an insert leaves its slot occupied
    a_insert_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (done_go && func_reg == kst_pkg::FUNC_ADD && !hit_reg && empty_found_reg)
        |=> valid_reg[$past(empty_idx_reg)])
        else $error("inserted slot not valid");

    // read pipeline only runs during a slot walk
    a_pipe_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        pipe_vld_reg |-> (state_reg == S_ADD || state_reg == S_TICK))
        else $error("read pipeline active outside walk");
`endif

endmodule
